### rtl/lrpd_pkg.sv
// ----------------------------------------------------------------------------
// lrpd_pkg: shared definitions for the life rle pattern decoder
// character codes, parse modes and result kinds
// ----------------------------------------------------------------------------
package lrpd_pkg;

  // default coordinate and count width
  localparam int COORD_BITS_DEF = 16;

  // output field widths
  localparam int KIND_W  = 2;
  localparam int FIELD_W = 16;
  localparam int OUT_DATA_W = 88;   // 5 x 16 + 1 flag, padded to whole bytes

  // characters of the pattern file
  localparam logic [7:0] CH_BANG    = 8'h21;  // '!'
  localparam logic [7:0] CH_DOLLAR  = 8'h24;  // '$'
  localparam logic [7:0] CH_HASH    = 8'h23;  // '#'
  localparam logic [7:0] CH_LOW_O   = 8'h6F;  // 'o'
  localparam logic [7:0] CH_UP_O    = 8'h4F;  // 'O'
  localparam logic [7:0] CH_LOW_X   = 8'h78;  // 'x'
  localparam logic [7:0] CH_UP_X    = 8'h58;  // 'X'
  localparam logic [7:0] CH_LF      = 8'h0A;  // newline
  localparam logic [7:0] CH_CR      = 8'h0D;  // carriage return
  localparam logic [7:0] CH_ZERO    = 8'h30;  // '0'
  localparam logic [7:0] CH_NINE    = 8'h39;  // '9'

  // parser modes
  typedef enum logic [3:0] {
    MODE_TOP     = 4'b0001,
    MODE_COMMENT = 4'b0010,
    MODE_HEADER  = 4'b0100,
    MODE_BODY    = 4'b1000
  } mode_t;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_HEADER = 2'd0;
  localparam logic [KIND_W-1:0] KIND_RUN    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_END    = 2'd2;

  // header number slots
  localparam logic [1:0] HFIELD_WIDTH  = 2'd0;
  localparam logic [1:0] HFIELD_HEIGHT = 2'd1;
  localparam logic [1:0] HFIELD_DONE   = 2'd2;

endpackage

### rtl/life_rle_pattern_decoder.sv
// ----------------------------------------------------------------------------
// life_rle_pattern_decoder: byte-stream decoder for rle cell pattern files
// parses comments, the x/y header line and the run-length body into results
// ----------------------------------------------------------------------------
// usage
//   in_*  : one byte of the pattern file per word, in file order
//   out_* : at most one result word per input byte; out_tuser carries the
//           kind (header sizes, live run, end of pattern), out_tdata the
//           row, column, length, header width/height and the outside flag
//   pipeline: a byte accepted is held in the input register, decoded out
//           of it, and its result is written to the result register that
//           drives out_*
//   throughput: one byte per cycle while out_* is not stalled; the parser
//           state update is a single saturating multiply-by-ten or add per byte
//   the input register can still take a byte while a result waits on out_*:
//           in_tready drops only when the input register holds a byte and
//           the result register is full and stalled
//   a stalled result holds its value until out_tready; bytes that give no
//           result still pass through once the output is free
//   reset (rst_n low, synchronous) returns the parser to top level with
//           all counts, coordinates and header sizes at zero and both
//           pipeline registers empty
// ----------------------------------------------------------------------------
module life_rle_pattern_decoder #(
  parameter int COORD_BITS = lrpd_pkg::COORD_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // input byte stream
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [7:0]                      in_tdata,   // [7:0] data_byte
  // result stream
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [lrpd_pkg::KIND_W-1:0]     out_tuser,  // [1:0] result_kind
  // [15:0] run_row, [31:16] run_column, [47:32] run_length,
  // [63:48] pattern_width, [79:64] pattern_height, [80] outside_area,
  // [87:81] zero
  output logic [lrpd_pkg::OUT_DATA_W-1:0] out_tdata
);

  localparam int FW = lrpd_pkg::FIELD_W;
  localparam logic [COORD_BITS-1:0] CMAX = {COORD_BITS{1'b1}};
  localparam logic [COORD_BITS-1:0] CONE = {{(COORD_BITS-1){1'b0}}, 1'b1};

  // saturating v * 10 + d
  function automatic logic [COORD_BITS-1:0] sat_digit(input logic [COORD_BITS-1:0] v,
                                                      input logic [3:0] d);
    logic [COORD_BITS+3:0] s;
    s = ({4'b0, v} << 3) + ({4'b0, v} << 1) + {{COORD_BITS{1'b0}}, d};
    return (s > {4'b0, CMAX}) ? CMAX : s[COORD_BITS-1:0];
  endfunction

  // saturating a + b
  function automatic logic [COORD_BITS-1:0] sat_add(input logic [COORD_BITS-1:0] a,
                                                    input logic [COORD_BITS-1:0] b);
    logic [COORD_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[COORD_BITS] ? CMAX : s[COORD_BITS-1:0];
  endfunction

  // fit a coordinate into a 16 bit output field
  function automatic logic [FW-1:0] to_field(input logic [COORD_BITS-1:0] v);
    logic [COORD_BITS+FW-1:0] w;
    w = {{FW{1'b0}}, v};
    return w[FW-1:0];
  endfunction

  // input register
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;

  // parser state
  lrpd_pkg::mode_t         mode_r, mode_nxt;
  logic [COORD_BITS-1:0]   run_count_r, run_count_nxt;
  logic                    count_seen_r, count_seen_nxt;
  logic [COORD_BITS-1:0]   cur_col_r, cur_col_nxt;
  logic [COORD_BITS-1:0]   cur_row_r, cur_row_nxt;
  logic [1:0]              hfield_r, hfield_nxt;
  logic [COORD_BITS-1:0]   hwidth_r, hwidth_nxt;
  logic [COORD_BITS-1:0]   hheight_r, hheight_nxt;

  // result register
  logic                        out_valid_r;
  logic [lrpd_pkg::KIND_W-1:0] out_kind_r;
  logic [FW-1:0]               out_row_r, out_col_r, out_len_r, out_w_r, out_h_r;
  logic                        out_outside_r;

  // result of the byte in the input register
  logic                        emit;
  logic [lrpd_pkg::KIND_W-1:0] emit_kind;
  logic                        emit_is_run;

  logic                  advance;
  logic                  is_digit;
  logic [3:0]            digit_val;
  logic [7:0]            c;
  logic [COORD_BITS-1:0] run_len;
  logic [COORD_BITS:0]   col_end;
  logic                  outside;

  assign advance   = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || advance;

  assign c         = s1_byte_r;
  assign is_digit  = c inside {[lrpd_pkg::CH_ZERO:lrpd_pkg::CH_NINE]};
  assign digit_val = c[3:0];

  // a run's length is the pending count, or one when no count came first
  assign run_len = count_seen_r ? run_count_r : CONE;
  assign col_end = {1'b0, cur_col_r} + {1'b0, run_len};
  assign outside = (cur_row_r >= hheight_r) || (col_end > {1'b0, hwidth_r});

  always_comb begin
    mode_nxt       = mode_r;
    run_count_nxt  = run_count_r;
    count_seen_nxt = count_seen_r;
    cur_col_nxt    = cur_col_r;
    cur_row_nxt    = cur_row_r;
    hfield_nxt     = hfield_r;
    hwidth_nxt     = hwidth_r;
    hheight_nxt    = hheight_r;
    emit           = 1'b0;
    emit_kind      = lrpd_pkg::KIND_HEADER;
    emit_is_run    = 1'b0;

    case (mode_r)
      lrpd_pkg::MODE_COMMENT: begin
        if (c == lrpd_pkg::CH_LF) mode_nxt = lrpd_pkg::MODE_TOP;
      end

      lrpd_pkg::MODE_HEADER: begin
        if (c == lrpd_pkg::CH_LF) begin
          // end of header line: report sizes and enter the body
          mode_nxt       = lrpd_pkg::MODE_BODY;
          count_seen_nxt = 1'b0;
          run_count_nxt  = '0;
          cur_row_nxt    = '0;
          cur_col_nxt    = '0;
          emit           = 1'b1;
          emit_kind      = lrpd_pkg::KIND_HEADER;
        end else if (is_digit) begin
          if (hfield_r == lrpd_pkg::HFIELD_WIDTH) begin
            hwidth_nxt     = sat_digit(hwidth_r, digit_val);
            count_seen_nxt = 1'b1;
          end else if (hfield_r == lrpd_pkg::HFIELD_HEIGHT) begin
            hheight_nxt    = sat_digit(hheight_r, digit_val);
            count_seen_nxt = 1'b1;
          end
        end else if (count_seen_r) begin
          // a number just ended: move on to the next slot
          if (hfield_r != lrpd_pkg::HFIELD_DONE) hfield_nxt = hfield_r + 2'd1;
          count_seen_nxt = 1'b0;
        end
      end

      lrpd_pkg::MODE_BODY: begin
        if (count_seen_r) begin
          if (is_digit) begin
            run_count_nxt = sat_digit(run_count_r, digit_val);
          end else begin
            count_seen_nxt = 1'b0;
            run_count_nxt  = '0;
            if (c == lrpd_pkg::CH_DOLLAR) begin
              cur_row_nxt = sat_add(cur_row_r, run_count_r);
              cur_col_nxt = '0;
            end else if (c inside {lrpd_pkg::CH_LOW_O, lrpd_pkg::CH_UP_O}) begin
              // a zero count gives no run
              if (run_count_r != '0) begin
                emit        = 1'b1;
                emit_kind   = lrpd_pkg::KIND_RUN;
                emit_is_run = 1'b1;
                cur_col_nxt = sat_add(cur_col_r, run_len);
              end
            end else begin
              // dead cells, and any other counted character such as a newline or bang
              cur_col_nxt = sat_add(cur_col_r, run_count_r);
            end
          end
        end else if (c inside {lrpd_pkg::CH_LF, lrpd_pkg::CH_CR}) begin
          // bare line breaks are ignored
        end else if (is_digit) begin
          run_count_nxt  = {{(COORD_BITS-4){1'b0}}, digit_val};
          count_seen_nxt = 1'b1;
        end else if (c == lrpd_pkg::CH_DOLLAR) begin
          cur_row_nxt = sat_add(cur_row_r, CONE);
          cur_col_nxt = '0;
        end else if (c inside {lrpd_pkg::CH_LOW_O, lrpd_pkg::CH_UP_O}) begin
          emit        = 1'b1;
          emit_kind   = lrpd_pkg::KIND_RUN;
          emit_is_run = 1'b1;
          cur_col_nxt = sat_add(cur_col_r, run_len);
        end else if (c == lrpd_pkg::CH_BANG) begin
          mode_nxt    = lrpd_pkg::MODE_TOP;
          cur_row_nxt = '0;
          cur_col_nxt = '0;
          emit        = 1'b1;
          emit_kind   = lrpd_pkg::KIND_END;
        end else begin
          cur_col_nxt = sat_add(cur_col_r, CONE);
        end
      end

      default: begin
        // top level
        mode_nxt = lrpd_pkg::MODE_TOP;
        if (c == lrpd_pkg::CH_HASH) begin
          mode_nxt = lrpd_pkg::MODE_COMMENT;
        end else if (c inside {lrpd_pkg::CH_LOW_X, lrpd_pkg::CH_UP_X}) begin
          mode_nxt       = lrpd_pkg::MODE_HEADER;
          hfield_nxt     = lrpd_pkg::HFIELD_WIDTH;
          hwidth_nxt     = '0;
          hheight_nxt    = '0;
          count_seen_nxt = 1'b0;
          run_count_nxt  = '0;
          cur_row_nxt    = '0;
          cur_col_nxt    = '0;
        end
      end
    endcase
  end

  // control: pipeline valids and parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      mode_r       <= lrpd_pkg::MODE_TOP;
      run_count_r  <= '0;
      count_seen_r <= 1'b0;
      cur_col_r    <= '0;
      cur_row_r    <= '0;
      hfield_r     <= lrpd_pkg::HFIELD_WIDTH;
      hwidth_r     <= '0;
      hheight_r    <= '0;
    end else begin
      if (in_tready) s1_valid_r <= in_tvalid;
      if (advance) out_valid_r <= s1_valid_r && emit;
      if (s1_valid_r && advance) begin
        mode_r       <= mode_nxt;
        run_count_r  <= run_count_nxt;
        count_seen_r <= count_seen_nxt;
        cur_col_r    <= cur_col_nxt;
        cur_row_r    <= cur_row_nxt;
        hfield_r     <= hfield_nxt;
        hwidth_r     <= hwidth_nxt;
        hheight_r    <= hheight_nxt;
      end
    end
  end

  // payload: input byte and result word
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) s1_byte_r <= in_tdata;
    if (s1_valid_r && advance && emit) begin
      out_kind_r    <= emit_kind;
      out_row_r     <= emit_is_run ? to_field(cur_row_r) : '0;
      out_col_r     <= emit_is_run ? to_field(cur_col_r) : '0;
      out_len_r     <= emit_is_run ? to_field(run_len) : '0;
      out_w_r       <= to_field(hwidth_r);
      out_h_r       <= to_field(hheight_r);
      out_outside_r <= emit_is_run && outside;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = {7'b0, out_outside_r, out_h_r, out_w_r, out_len_r, out_col_r, out_row_r};

endmodule
